// ===== sv/npm_pkg.sv =====
// Shared types and constants for the noisy pixel mask engine.
package npm_pkg;

	localparam int TOTAL_W      = 48;
	localparam int FACTOR_W     = 8;
	localparam int COORD_W      = 8;
	localparam int HIT_COUNT_W  = 32;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd10;

	localparam logic KIND_HIT   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] pixel_column;
		logic [COORD_W-1:0] pixel_row;
	} in_item_t;

	typedef struct packed {
		logic [COORD_W-1:0]     queried_column;
		logic [COORD_W-1:0]     queried_row;
		logic [HIT_COUNT_W-1:0] hit_count;
		logic                   masked;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic read;
		logic hit_wr;
		logic mul;
		logic load_out;
	} npm_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic is_query;
		logic out_free;
	} npm_stat_t;

endpackage

// ===== sv/noisy_pixel_mask_engine.sv =====
// Noisy pixel mask engine: per-pixel hit histogram with mean-occupancy mask decision.
// After reset the block clears its counter memory, one pixel a cycle, for all
// ROWS * COLUMNS pixels (65536 with the defaults), and takes no item until that pass is
// done. Each item then goes through the counter memory in steps: a hit through capture,
// registered read and write-back of the saturated count and total, a query through
// capture, read, registered multiplies and compare into the output register, which
// waits while that register's previous beat has not been taken. A new item is accepted
// while a finished result still waits at the output. The mask factor may be written at
// any idle moment and applies to later queries.
module noisy_pixel_mask_engine import npm_pkg::*; #(
	parameter int ROWS       = 256,
	parameter int COLUMNS    = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_we,
	input  logic [FACTOR_W-1:0] cfg_wdata
);

	npm_cmd_t  cmd;
	npm_stat_t stat;

	npm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	npm_datapath #(
		.ROWS       (ROWS),
		.COLUMNS    (COLUMNS),
		.COUNT_BITS (COUNT_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// A result is never loaded over a beat that has not been taken.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over a pending beat");

	// An accepted item is followed by its counter read.
	a_accept_read: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.read)
		else $error("accepted item not followed by a read");

	// The clearing pass and the hit update never share the write port.
	a_write_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_wr, cmd.hit_wr}))
		else $error("clear and hit write together");

	// A result only appears after a load.
	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.load_out))
		else $error("output valid without a load");

endmodule

// ===== sv/npm_ctrl.sv =====
// Controller state machine sequencing clear, read-modify-write and query.
module npm_ctrl import npm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  npm_stat_t stat,
	output npm_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (stat.clear_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) state_q <= ST_READ;
				end
				ST_READ: begin
					state_q <= stat.is_query ? ST_MUL : ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd          = '0;
		cmd.clear_wr = (state_q == ST_CLEAR);
		cmd.capture  = (state_q == ST_IDLE) && in_valid;
		cmd.read     = (state_q == ST_READ);
		cmd.hit_wr   = (state_q == ST_UPDATE);
		cmd.mul      = (state_q == ST_MUL);
		cmd.load_out = (state_q == ST_DONE) && stat.out_free;
	end

endmodule

// ===== sv/npm_datapath.sv =====
// Datapath: counter memory, running total, mask factor, compare and output register.
module npm_datapath import npm_pkg::*; #(
	parameter int ROWS       = 256,
	parameter int COLUMNS    = 256,
	parameter int COUNT_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  npm_cmd_t            cmd,
	output npm_stat_t           stat,
	input  in_item_t            in_data,
	input  logic                cfg_we,
	input  logic [FACTOR_W-1:0] cfg_wdata,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data
);

	localparam int PIXELS = ROWS * COLUMNS;
	localparam int ADDR_W = $clog2(PIXELS);
	localparam int PIX_W  = ADDR_W + 1;
	localparam int LHS_W  = COUNT_BITS + PIX_W;
	localparam int RHS_W  = FACTOR_W + TOTAL_W;
	localparam int CMP_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIXELS - 1);

	logic [COUNT_BITS-1:0] mem [PIXELS];

	logic [ADDR_W-1:0]     clr_addr_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  inside_q;
	logic                  kind_q;
	logic [COORD_W-1:0]    col_q;
	logic [COORD_W-1:0]    row_q;
	logic [COUNT_BITS-1:0] rd_data_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [FACTOR_W-1:0]   factor_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [LHS_W-1:0]      lhs_q;
	logic [RHS_W-1:0]      rhs_q;
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic                  in_inside;
	logic [ADDR_W-1:0]     in_addr;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [COUNT_BITS-1:0] wr_data;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  masked;

	assign in_inside = (int'(in_data.pixel_column) < COLUMNS) &&
		(int'(in_data.pixel_row) < ROWS);
	assign in_addr = ADDR_W'(in_data.pixel_row) +
		ADDR_W'(ROWS) * ADDR_W'(in_data.pixel_column);

	// The write port is shared by the clearing pass and the hit update.
	always_comb begin
		wr_en   = cmd.clear_wr || (cmd.hit_wr && inside_q);
		wr_addr = cmd.clear_wr ? clr_addr_q : addr_q;
		wr_data = '0;
		if (!cmd.clear_wr) begin
			wr_data = (rd_data_q == '1) ? rd_data_q : rd_data_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.read) rd_data_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			total_q    <= '0;
			factor_q   <= FACTOR_RESET;
		end else begin
			if (cmd.clear_wr) clr_addr_q <= clr_addr_q + 1'b1;
			if (cmd.hit_wr && inside_q && total_q != '1) total_q <= total_q + 1'b1;
			if (cfg_we) factor_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q   <= in_addr;
			inside_q <= in_inside;
			kind_q   <= in_data.kind;
			col_q    <= in_data.pixel_column;
			row_q    <= in_data.pixel_row;
		end
	end

	assign rd_count = inside_q ? rd_data_q : '0;

	// Mean test without division: count * PIXELS > factor * total.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			count_q <= rd_count;
			lhs_q   <= LHS_W'(rd_count) * LHS_W'(PIXELS);
			rhs_q   <= RHS_W'(factor_q) * RHS_W'(total_q);
		end
	end

	assign masked = inside_q && (CMP_W'(lhs_q) > CMP_W'(rhs_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q.queried_column <= col_q;
			out_data_q.queried_row    <= row_q;
			out_data_q.hit_count      <= HIT_COUNT_W'(count_q);
			out_data_q.masked         <= masked;
		end
	end

	assign stat.clear_last = (clr_addr_q == LAST_ADDR);
	assign stat.is_query   = (kind_q == KIND_QUERY);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
